/* rtl/core/idf_pkg.sv */
// ----------------------------------------------------------------------------
// idf_pkg
// Shared types, constants and helper functions of the intensity direction finder.
// ----------------------------------------------------------------------------
package idf_pkg;

    localparam int SAMPLE_WIDTH        = 16;
    localparam int BIN_WIDTH           = 11;
    localparam int LEVEL_WIDTH         = 32;
    localparam int ANGLE_WIDTH         = 16;
    localparam int PROD_WIDTH          = 2 * SAMPLE_WIDTH + 2;
    localparam int CORDIC_WIDTH        = 60;
    localparam int ZACC_WIDTH          = 32;
    localparam int GUARD_SHIFT         = 24;
    localparam int ATAN_ENTRIES        = 24;
    localparam int CORDIC_STEPS_DEF    = 16;

    // Sequencer states, one transaction at a time
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_FEED_AZ,
        ST_FEED_EL,
        ST_WAIT_AZ,
        ST_WAIT_EL,
        ST_UPDATE
    } state_t;

    // Data handed from one CORDIC cell to the next
    typedef struct packed {
        logic                           vld;
        logic signed [CORDIC_WIDTH-1:0] x;
        logic signed [CORDIC_WIDTH-1:0] y;
        logic signed [ZACC_WIDTH-1:0]   z;
    } cordic_t;

    // atan(2^-i), pi = 2^31
    function automatic logic signed [ZACC_WIDTH-1:0] atan_entry(input int idx);
        logic signed [ZACC_WIDTH-1:0] v;
        case (idx)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10680862;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41722;
            15:      v = 32'sd20861;
            16:      v = 32'sd10430;
            17:      v = 32'sd5215;
            18:      v = 32'sd2608;
            19:      v = 32'sd1304;
            20:      v = 32'sd652;
            21:      v = 32'sd326;
            22:      v = 32'sd163;
            23:      v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Sign-extend a product-width value and apply the guard scale
    function automatic logic signed [CORDIC_WIDTH-1:0] guard_scale(
        input logic signed [PROD_WIDTH-1:0] v);
        return {{(CORDIC_WIDTH-PROD_WIDTH-GUARD_SHIFT){v[PROD_WIDTH-1]}}, v,
                {GUARD_SHIFT{1'b0}}};
    endfunction

    // Round half away from zero to pi = 32768, clamp to +-pi/2
    function automatic logic signed [ANGLE_WIDTH-1:0] round_angle(
        input logic signed [ZACC_WIDTH-1:0] z);
        logic [ZACC_WIDTH-1:0] mag;
        logic [ZACC_WIDTH:0]   sum;
        logic [16:0]           q;
        logic [15:0]           m;
        mag = z[ZACC_WIDTH-1] ? ZACC_WIDTH'(-z) : ZACC_WIDTH'(z);
        sum = {1'b0, mag} + 33'd32768;
        q   = sum[32:16];
        m   = (q > 17'd16384) ? 16'd16384 : q[15:0];
        return z[ZACC_WIDTH-1] ? -signed'(m) : signed'(m);
    endfunction

endpackage

/* rtl/core/idf_sqrt.sv */
// ----------------------------------------------------------------------------
// idf_sqrt
// Bit-pair restoring integer square root, floor(sqrt(operand)).
// ----------------------------------------------------------------------------
module idf_sqrt import idf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] rad_reg,  rad_next;
    logic [33:0] rem_reg,  rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic [35:0] rem_sh;
    logic [35:0] trial;

    // One result bit per cycle
    always_comb begin
        rem_sh    = {rem_reg, rad_reg[63:62]};
        trial     = {2'b00, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rad_next  = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = 34'(rem_sh - trial);
                root_next = {root_reg[30:0], 1'b1};
            end else begin
                rem_next  = rem_sh[33:0];
                root_next = {root_reg[30:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* rtl/core/idf_cordic_cell.sv */
// ----------------------------------------------------------------------------
// idf_cordic_cell
// One vectoring CORDIC micro-rotation with a fixed shift, registered output.
// ----------------------------------------------------------------------------
module idf_cordic_cell import idf_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cordic_t din,
    output cordic_t dout
);

    cordic_t stage_reg, stage_next;
    logic signed [CORDIC_WIDTH-1:0] xs, ys;

    // Rotate toward the x axis; y == 0 rotates the negative way
    always_comb begin
        xs = din.x >>> IDX;
        ys = din.y >>> IDX;
        stage_next.vld = din.vld;
        if (din.y > 0) begin
            stage_next.x = din.x + ys;
            stage_next.y = din.y - xs;
            stage_next.z = din.z + atan_entry(IDX);
        end else begin
            stage_next.x = din.x - ys;
            stage_next.y = din.y + xs;
            stage_next.z = din.z - atan_entry(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
        if (!aresetn) begin
            stage_reg.vld <= 1'b0;
        end
    end

    assign dout = stage_reg;

endmodule

/* rtl/core/bformat_intensity_direction_finder.sv */
// ----------------------------------------------------------------------------
// bformat_intensity_direction_finder
// Per-bin active intensity, level and direction; reports the strongest bin
// of each frame on the last bin.
// ----------------------------------------------------------------------------
// Channel  | Ports                                  | Transaction
// ---------+----------------------------------------+------------------------
// input    | s_valid, s_ready, s_w/x/y/z_real/imag, | one frequency bin
//          | s_last_bin                             |
// result   | m_valid, m_ready, m_azimuth,           | one per frame, on the
//          | m_elevation, m_peak_bin, m_peak_level  | last bin
//
// A bin is accepted only while idle and then passes the multiply, square
// and sum steps, the bit-serial square roots, the CORDIC cell row and the
// update step.
// Reset (aresetn low, synchronous) clears the frame state and the output.
// A finished frame result waits in the output register; a following last
// bin holds in the update step until that register is free.
// ----------------------------------------------------------------------------
module bformat_intensity_direction_finder import idf_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_w_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_w_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_x_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_x_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_y_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_y_imag,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_z_real,
    input  logic signed [SAMPLE_WIDTH-1:0]  s_z_imag,
    input  logic                            s_last_bin,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ANGLE_WIDTH-1:0]   m_azimuth,
    output logic signed [ANGLE_WIDTH-1:0]   m_elevation,
    output logic [BIN_WIDTH-1:0]            m_peak_bin,
    output logic [LEVEL_WIDTH-1:0]          m_peak_level
);

    state_t state_reg, state_next;

    logic signed [PROD_WIDTH-1:0] ix_reg, iy_reg, iz_reg;
    logic                         last_reg;
    logic [63:0]                  sqx_reg, sqy_reg, sqz_reg;
    logic [PROD_WIDTH-1:0]        abs_x, abs_y, abs_z;
    logic signed [PROD_WIDTH-1:0] cx, cy;

    logic        sq_start;
    logic [63:0] hsq, tot;
    logic        sqh_busy, sqt_busy;
    logic [31:0] root_h, root_t;

    cordic_t chain [CORDIC_STEPS+1];

    logic signed [ANGLE_WIDTH-1:0] azi_reg, ele_reg;

    logic [BIN_WIDTH-1:0]          bin_cnt_reg;
    logic [LEVEL_WIDTH-1:0]        best_level_reg;
    logic signed [ANGLE_WIDTH-1:0] best_azi_reg, best_ele_reg;
    logic [BIN_WIDTH-1:0]          best_idx_reg;
    logic                          have_best_reg;

    logic                          m_valid_reg;
    logic signed [ANGLE_WIDTH-1:0] m_azi_reg, m_ele_reg;
    logic [BIN_WIDTH-1:0]          m_bin_reg;
    logic [LEVEL_WIDTH-1:0]        m_level_reg;

    logic                          s_accept, upd, out_free, emit, commit;
    logic [LEVEL_WIDTH-1:0]        nb_level;
    logic signed [ANGLE_WIDTH-1:0] nb_azi, nb_ele;
    logic [BIN_WIDTH-1:0]          nb_idx;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Intensity components, registered on accept
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ix_reg   <= PROD_WIDTH'(s_w_real * s_x_real) + PROD_WIDTH'(s_w_imag * s_x_imag);
            iy_reg   <= PROD_WIDTH'(s_w_real * s_y_real) + PROD_WIDTH'(s_w_imag * s_y_imag);
            iz_reg   <= PROD_WIDTH'(s_w_real * s_z_real) + PROD_WIDTH'(s_w_imag * s_z_imag);
            last_reg <= s_last_bin;
        end
    end

    // Magnitudes and squares
    assign abs_x = ix_reg[PROD_WIDTH-1] ? PROD_WIDTH'(-ix_reg) : PROD_WIDTH'(ix_reg);
    assign abs_y = iy_reg[PROD_WIDTH-1] ? PROD_WIDTH'(-iy_reg) : PROD_WIDTH'(iy_reg);
    assign abs_z = iz_reg[PROD_WIDTH-1] ? PROD_WIDTH'(-iz_reg) : PROD_WIDTH'(iz_reg);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SQUARE) begin
            sqx_reg <= abs_x[31:0] * abs_x[31:0];
            sqy_reg <= abs_y[31:0] * abs_y[31:0];
            sqz_reg <= abs_z[31:0] * abs_z[31:0];
        end
    end

    // Square roots of the horizontal and full energies
    assign sq_start = (state_reg == ST_SUM);
    assign hsq      = sqx_reg + sqy_reg;
    assign tot      = sqx_reg + sqy_reg + sqz_reg;

    idf_sqrt u_sqrt_h (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .operand (hsq),
        .busy    (sqh_busy),
        .root    (root_h)
    );

    idf_sqrt u_sqrt_t (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .operand (tot),
        .busy    (sqt_busy),
        .root    (root_t)
    );

    // Azimuth folded into the right half plane
    assign cx = signed'(abs_x);
    assign cy = ix_reg[PROD_WIDTH-1] ? -iy_reg : iy_reg;

    // Head of the CORDIC row: azimuth vector, then elevation vector
    always_comb begin
        chain[0].vld = (state_reg == ST_FEED_AZ) || (state_reg == ST_FEED_EL);
        chain[0].z   = '0;
        if (state_reg == ST_FEED_EL) begin
            chain[0].x = guard_scale(signed'(PROD_WIDTH'(root_h)));
            chain[0].y = guard_scale(iz_reg);
        end else begin
            chain[0].x = guard_scale(cx);
            chain[0].y = guard_scale(cy);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        idf_cordic_cell #(.IDX(i)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .din     (chain[i]),
            .dout    (chain[i+1])
        );
    end

    // Capture angles at the tail; a zero Ix gives a zero direction
    always_ff @(posedge aclk) begin
        if (chain[CORDIC_STEPS].vld) begin
            if (state_reg == ST_WAIT_AZ) begin
                azi_reg <= (ix_reg == '0) ? '0 : round_angle(chain[CORDIC_STEPS].z);
            end else begin
                ele_reg <= (ix_reg == '0) ? '0 : round_angle(chain[CORDIC_STEPS].z);
            end
        end
    end

    // Running maximum, earliest bin wins a tie
    assign upd      = !have_best_reg || (root_t > best_level_reg);
    assign nb_level = upd ? root_t      : best_level_reg;
    assign nb_azi   = upd ? azi_reg     : best_azi_reg;
    assign nb_ele   = upd ? ele_reg     : best_ele_reg;
    assign nb_idx   = upd ? bin_cnt_reg : best_idx_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == ST_UPDATE) && (!last_reg || out_free);
    assign emit     = commit && last_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_accept) state_next = ST_SQUARE;
            ST_SQUARE:  state_next = ST_SUM;
            ST_SUM:     state_next = ST_SQRT;
            ST_SQRT:    if (!sqh_busy && !sqt_busy) state_next = ST_FEED_AZ;
            ST_FEED_AZ: state_next = ST_FEED_EL;
            ST_FEED_EL: state_next = ST_WAIT_AZ;
            ST_WAIT_AZ: if (chain[CORDIC_STEPS].vld) state_next = ST_WAIT_EL;
            ST_WAIT_EL: if (chain[CORDIC_STEPS].vld) state_next = ST_UPDATE;
            ST_UPDATE:  if (commit) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_cnt_reg    <= '0;
            best_level_reg <= '0;
            best_azi_reg   <= '0;
            best_ele_reg   <= '0;
            best_idx_reg   <= '0;
            have_best_reg  <= 1'b0;
        end else if (emit) begin
            bin_cnt_reg    <= '0;
            best_level_reg <= '0;
            best_azi_reg   <= '0;
            best_ele_reg   <= '0;
            best_idx_reg   <= '0;
            have_best_reg  <= 1'b0;
        end else if (commit) begin
            bin_cnt_reg    <= bin_cnt_reg + 1'b1;
            best_level_reg <= nb_level;
            best_azi_reg   <= nb_azi;
            best_ele_reg   <= nb_ele;
            best_idx_reg   <= nb_idx;
            have_best_reg  <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_azi_reg   <= nb_azi;
            m_ele_reg   <= nb_ele;
            m_bin_reg   <= nb_idx;
            m_level_reg <= nb_level;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_azimuth    = m_azi_reg;
    assign m_elevation  = m_ele_reg;
    assign m_peak_bin   = m_bin_reg;
    assign m_peak_level = m_level_reg;

    // A result appears only after the update step of a last bin
    a_emit_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_UPDATE && last_reg))
        else $error("result raised outside a last-bin update");

    // Square roots run only while the sequencer waits for them
    a_sqrt_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (sqh_busy || sqt_busy) |-> (state_reg == ST_SQRT))
        else $error("square root busy outside its window");

    // CORDIC results only come out while they are awaited
    a_cordic_window: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[CORDIC_STEPS].vld |-> (state_reg == ST_WAIT_AZ || state_reg == ST_WAIT_EL))
        else $error("CORDIC output with nobody waiting");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !emit)
        else $error("result overwritten before taken");

endmodule

/* sim/idf_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idf_scoreboard
// Watches the bin and frame result channels of the direction finder, predicts
// the strongest bin of each frame and compares every result field by field.
// ----------------------------------------------------------------------------
module idf_scoreboard import idf_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_w_real,
    input  logic signed [SAMPLE_WIDTH-1:0] s_w_imag,
    input  logic signed [SAMPLE_WIDTH-1:0] s_x_real,
    input  logic signed [SAMPLE_WIDTH-1:0] s_x_imag,
    input  logic signed [SAMPLE_WIDTH-1:0] s_y_real,
    input  logic signed [SAMPLE_WIDTH-1:0] s_y_imag,
    input  logic signed [SAMPLE_WIDTH-1:0] s_z_real,
    input  logic signed [SAMPLE_WIDTH-1:0] s_z_imag,
    input  logic                           s_last_bin,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [ANGLE_WIDTH-1:0]  m_azimuth,
    input  logic signed [ANGLE_WIDTH-1:0]  m_elevation,
    input  logic [BIN_WIDTH-1:0]           m_peak_bin,
    input  logic [LEVEL_WIDTH-1:0]         m_peak_level,
    output int                             mismatches,
    output int                             frames_pending
);

    typedef struct packed {
        logic signed [ANGLE_WIDTH-1:0] azimuth;
        logic signed [ANGLE_WIDTH-1:0] elevation;
        logic [BIN_WIDTH-1:0]          peak_bin;
        logic [LEVEL_WIDTH-1:0]        peak_level;
    } peak_t;

    localparam logic signed [31:0] ATAN_TABLE [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    peak_t                 peak_queue[$];
    logic [BIN_WIDTH-1:0]  bin_count;
    logic [LEVEL_WIDTH-1:0] top_level;
    logic signed [15:0]    top_azimuth, top_elevation;
    logic [BIN_WIDTH-1:0]  top_bin;
    logic                  seen_bin;

    assign frames_pending = peak_queue.size();

    // Integer square root, floor
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Vectoring rotation, angle rounded half away from zero and clamped
    function automatic logic signed [15:0] vector_angle(input longint x, input longint y);
        longint zacc, xs, ys, mag;
        zacc = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; zacc = zacc + ATAN_TABLE[i];
            end else begin
                x = x - ys; y = y + xs; zacc = zacc - ATAN_TABLE[i];
            end
        end
        mag = (zacc < 0) ? -zacc : zacc;
        mag = (mag + 32768) >>> 16;
        if (mag > 16384) mag = 16384;
        return (zacc < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Bin prediction and result comparison
    always @(posedge aclk) begin
        longint ix, iy, iz, ax, ay, az;
        logic [63:0] horiz, mag;
        logic [31:0] level;
        logic signed [15:0] azi, ele;
        peak_t want;
        if (!aresetn) begin
            bin_count = 0; top_level = 0; top_azimuth = 0;
            top_elevation = 0; top_bin = 0; seen_bin = 0;
            mismatches = 0;
            peak_queue.delete();
        end else begin
            if (s_valid && s_ready) begin
                ix = longint'(s_w_real) * s_x_real + longint'(s_w_imag) * s_x_imag;
                iy = longint'(s_w_real) * s_y_real + longint'(s_w_imag) * s_y_imag;
                iz = longint'(s_w_real) * s_z_real + longint'(s_w_imag) * s_z_imag;
                ax = ix < 0 ? -ix : ix;
                ay = iy < 0 ? -iy : iy;
                az = iz < 0 ? -iz : iz;
                horiz = ax * ax + ay * ay;
                mag   = floor_sqrt(horiz + az * az);
                level = (mag > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mag[31:0];
                azi = 0;
                ele = 0;
                // a zero front-back term leaves the direction at zero
                if (ix != 0) begin
                    azi = vector_angle(ax <<< 24, (ix < 0 ? -iy : iy) <<< 24);
                    ele = vector_angle(longint'(floor_sqrt(horiz)) <<< 24, iz <<< 24);
                end
                if (!seen_bin || level > top_level) begin
                    seen_bin = 1; top_level = level; top_azimuth = azi;
                    top_elevation = ele; top_bin = bin_count;
                end
                bin_count = bin_count + 1'b1;
                if (s_last_bin) begin
                    peak_queue.push_back('{top_azimuth, top_elevation, top_bin, top_level});
                    bin_count = 0; top_level = 0; top_azimuth = 0;
                    top_elevation = 0; top_bin = 0; seen_bin = 0;
                end
            end
            if (m_valid && m_ready) begin
                if (peak_queue.size() == 0) begin
                    report_mismatch("unexpected frame result", 1, 0);
                end else begin
                    want = peak_queue.pop_front();
                    if (m_azimuth !== want.azimuth)
                        report_mismatch("azimuth", m_azimuth, want.azimuth);
                    if (m_elevation !== want.elevation)
                        report_mismatch("elevation", m_elevation, want.elevation);
                    if (m_peak_bin !== want.peak_bin)
                        report_mismatch("peak_bin", m_peak_bin, want.peak_bin);
                    if (m_peak_level !== want.peak_level)
                        report_mismatch("peak_level", m_peak_level, want.peak_level);
                end
            end
        end
    end

endmodule

/* sim/tb_bformat_intensity_direction_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bformat_intensity_direction_finder
// Drives directed and random frequency bins with random gaps and result
// back-pressure; a scoreboard beside the block checks each frame result.
// ----------------------------------------------------------------------------
module tb_bformat_intensity_direction_finder;
    import idf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic aclk, aresetn;
    logic s_valid, s_ready, s_last_bin;
    logic signed [SAMPLE_WIDTH-1:0] s_w_real, s_w_imag, s_x_real, s_x_imag;
    logic signed [SAMPLE_WIDTH-1:0] s_y_real, s_y_imag, s_z_real, s_z_imag;
    logic m_valid, m_ready;
    logic signed [ANGLE_WIDTH-1:0] m_azimuth, m_elevation;
    logic [BIN_WIDTH-1:0] m_peak_bin;
    logic [LEVEL_WIDTH-1:0] m_peak_level;
    int mismatches, frames_pending, cycles;
    bit quiet, hold_off;

    bformat_intensity_direction_finder dut (.*);
    idf_scoreboard scoreboard (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side back-pressure
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_off) m_ready <= 0;
            else m_ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    // Send one bin and wait for its acceptance; valid stays up afterwards
    // until the next transaction or an idle cycle replaces it
    task automatic send_bin(input logic [15:0] wr, wi, xr, xi, yr, yi, zr, zi,
                            input logic last);
        if (!quiet) begin
            while ($urandom_range(99) < 13) begin
                s_valid <= 0;
                @(negedge aclk);
            end
        end
        s_valid <= 1; s_w_real <= wr; s_w_imag <= wi; s_x_real <= xr;
        s_x_imag <= xi; s_y_real <= yr; s_y_imag <= yi; s_z_real <= zr;
        s_z_imag <= zi; s_last_bin <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(7)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input logic last);
        logic [15:0] s [8];
        foreach (s[i]) s[i] = pick_sample();
        if ($urandom_range(9) == 0) begin
            s[2] = 0; s[3] = 0;
        end
        send_bin(s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7], last);
    endtask

    initial begin
        int sent, len;
        quiet = 0; hold_off = 0;
        s_valid = 0; s_last_bin = 0;
        {s_w_real, s_w_imag, s_x_real, s_x_imag} = '0;
        {s_y_real, s_y_imag, s_z_real, s_z_imag} = '0;
        aresetn = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: extremes, zero front-back term, ties, single-bin frames
        send_bin(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF, 16'h7FFF, 1);
        send_bin(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 1);
        send_bin(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
                 16'h7FFF, 16'h8000, 1);
        send_bin(16'h0100, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0);
        send_bin(16'h0100, 0, 16'h0100, 0, 0, 0, 0, 0, 0);
        send_bin(16'h0100, 0, 16'hFF00, 0, 16'h0100, 0, 16'hFF00, 0, 1);
        send_bin(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_bin(0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_bin(16'h1000, 0, 16'h1000, 0, 0, 0, 0, 0, 0);
        send_bin(16'h1000, 0, 16'hF000, 0, 0, 0, 0, 0, 0);
        send_bin(16'h1000, 0, 16'h1000, 0, 16'h0001, 0, 0, 0, 1);
        send_bin(16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                 16'hAAAA, 16'h5555, 1);
        for (int i = 0; i < 8; i++) send_random(i == 7);

        // Queue results behind a long receiver hold-off
        hold_off = 1;
        fork
            begin
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 24; i++) send_random(i % 3 == 2);
        join
        hold_off = 0;

        // Random frames: mostly short, a few long ones
        sent = 0;
        while (sent < 1350) begin
            quiet = (sent > 500 && sent < 700);
            len = ($urandom_range(19) == 0) ? $urandom_range(100, 200)
                                            : $urandom_range(1, 12);
            for (int i = 0; i < len; i++) send_random(i == len - 1);
            sent += len;
            // sender pause until the block has drained
            if ($urandom_range(15) == 0) begin
                s_valid <= 0;
                do @(negedge aclk); while (frames_pending != 0);
            end
        end
        quiet = 0;

        s_valid <= 0;
        do @(negedge aclk); while (frames_pending != 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
